/* design/rskc_pkg.sv */
// Shared types, constants and constant functions for the RMS soft-knee compressor.
// No dependencies; used by every module of the block.
package rskc_pkg;

    localparam int RMS_WINDOW_DEF = 512;
    localparam int LOOKAHEAD_DEF  = 64;

    localparam int SUM_W  = 40;
    localparam int SQ_W   = 31;
    localparam int ENV_W  = 25;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 24;

    localparam logic [17:0] LOG_SCALE    = 18'd197283;
    localparam logic [15:0] LEVEL_OFFSET = 16'd23119;
    localparam logic [13:0] EXP_SCALE    = 14'd10885;
    localparam logic [ENV_W-1:0] UNITY   = 25'd16777216;

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_KNEE      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_REDUCTION = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ATTACK    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RELEASE   = 3'd4;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
    localparam logic [12:0]        KNEE_RST      = 13'd2048;
    localparam logic [15:0]        REDUCTION_RST = 16'd56174;
    localparam logic [23:0]        ATTACK_RST    = 24'd3804;
    localparam logic [23:0]        RELEASE_RST   = 24'd761;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [12:0]        knee_width_db;
        logic [15:0]        reduction_fraction;
        logic [23:0]        attack_coef;
        logic [23:0]        release_coef;
    } rskc_cfg_t;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic signed [15:0] level;
        logic signed [15:0] delayed;
    } rskc_item_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } rskc_front_st_t;

    typedef logic [15:0][30:0] exp_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int i = 0; i < 32; i++) begin
            if (b > x) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-2^-k) in Q1.30 for k = 1..16, by repeated square roots
    function automatic exp_tab_t exp_table();
        exp_tab_t    tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int k = 0; k < 16; k++) begin
            tab[k] = c[30:0];
            c = isqrt64(c << 30);
        end
        return tab;
    endfunction

endpackage

/* design/rskc_queue.sv */
// Two-entry queue of level/delayed-sample items between front and back.
// Depends on rskc_pkg for the item type.
module rskc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rskc_pkg::rskc_item_t wdata,
    output logic                full,
    input  logic                pop,
    output rskc_pkg::rskc_item_t rdata,
    output logic                empty
);

    rskc_pkg::rskc_item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= ~wptr_reg;
            if (do_pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

/* design/rskc_front.sv */
// Front end: takes samples, keeps the square and lookahead rings, the running
// sum, and the log2-based level detector. Depends on rskc_pkg.
module rskc_front #(
    parameter int RMS_WINDOW = rskc_pkg::RMS_WINDOW_DEF,
    parameter int LOOKAHEAD  = rskc_pkg::LOOKAHEAD_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [15:0]      in_sample,
    output logic                    q_push,
    input  logic                    q_full,
    output rskc_pkg::rskc_item_t    q_data,
    output rskc_pkg::rskc_front_st_t status
);

    localparam int SQ_AW     = (RMS_WINDOW > 1) ? $clog2(RMS_WINDOW) : 1;
    localparam int LA_AW     = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
    localparam int CLR_DEPTH = (RMS_WINDOW > LOOKAHEAD) ? RMS_WINDOW : LOOKAHEAD;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam int SW        = rskc_pkg::SUM_W;

    typedef enum logic [7:0] {
        F_CLR  = 8'b0000_0001,
        F_IDLE = 8'b0000_0010,
        F_READ = 8'b0000_0100,
        F_SUM  = 8'b0000_1000,
        F_NORM = 8'b0001_0000,
        F_LOG  = 8'b0010_0000,
        F_LVL  = 8'b0100_0000,
        F_PUSH = 8'b1000_0000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [rskc_pkg::SQ_W-1:0] sq_mem [RMS_WINDOW];
    logic [15:0]               la_mem [LOOKAHEAD];

    logic [SQ_AW-1:0]          pos_reg;
    logic [LA_AW-1:0]          lpos_reg;
    logic [CLR_W-1:0]          clr_reg;
    logic [SW-1:0]             sum_reg;
    logic [rskc_pkg::SQ_W-1:0] sq_rd_reg, sq_reg, old_reg;
    logic [15:0]               la_rd_reg;
    logic signed [15:0]        x_reg, d_reg;
    logic [SW-1:0]             m_reg;
    logic [5:0]                e_reg;
    logic [30:0]               mant_reg;
    logic [15:0]               lg_reg;
    logic [3:0]                k_reg;
    logic [39:0]               lprod_reg;
    logic                      zero_reg;

    logic                      accept;
    logic                      sq_we, la_we;
    logic [SQ_AW-1:0]          sq_addr;
    logic [LA_AW-1:0]          la_addr;
    logic [rskc_pkg::SQ_W-1:0] sq_wdata;
    logic [15:0]               la_wdata;
    logic [SW-1:0]             sum_next;
    logic [61:0]               msq;
    logic [40:0]               rnd;
    logic signed [15:0]        level;
    logic [31:0]               x_sq;

    assign accept   = push && !full;
    assign full     = (state_reg != F_IDLE);
    assign x_sq     = 32'($signed(x_reg) * $signed(x_reg));
    assign sum_next = sum_reg + {{(SW - rskc_pkg::SQ_W){1'b0}}, sq_reg}
                              - {{(SW - rskc_pkg::SQ_W){1'b0}}, old_reg};
    assign msq      = {31'd0, mant_reg} * {31'd0, mant_reg};
    assign rnd      = {1'b0, lprod_reg} + 41'd8388608;
    assign level    = zero_reg ? 16'sh8000
                               : $signed(rnd[39:24]) - $signed(rskc_pkg::LEVEL_OFFSET);

    assign q_data.level   = level;
    assign q_data.delayed = d_reg;
    assign q_push         = (state_reg == F_PUSH) && !q_full;

    assign status.clearing = (state_reg == F_CLR);
    assign status.busy     = (state_reg != F_IDLE) && (state_reg != F_CLR);

    // ring writes: clearing sweep after reset, then one entry per item
    always_comb
    begin
        sq_we    = 1'b0;
        la_we    = 1'b0;
        sq_addr  = pos_reg;
        la_addr  = lpos_reg;
        sq_wdata = sq_reg;
        la_wdata = x_reg;
        if (state_reg == F_CLR)
        begin
            sq_we    = (clr_reg < CLR_W'(RMS_WINDOW));
            la_we    = (clr_reg < CLR_W'(LOOKAHEAD));
            sq_addr  = clr_reg[SQ_AW-1:0];
            la_addr  = clr_reg[LA_AW-1:0];
            sq_wdata = '0;
            la_wdata = '0;
        end
        else
        begin
            sq_we = (state_reg == F_SUM);
            la_we = (state_reg == F_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_we) sq_mem[sq_addr] <= sq_wdata;
        sq_rd_reg <= sq_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (la_we) la_mem[la_addr] <= la_wdata;
        la_rd_reg <= la_mem[lpos_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_CLR:  if (clr_reg == CLR_W'(CLR_DEPTH - 1)) state_next = F_IDLE;
            F_IDLE: if (accept) state_next = F_READ;
            F_READ: state_next = F_SUM;
            F_SUM:  state_next = (sum_next == '0) ? F_PUSH : F_NORM;
            F_NORM: if (m_reg[SW-1]) state_next = F_LOG;
            F_LOG:  if (k_reg == 4'd15) state_next = F_LVL;
            F_LVL:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_CLR;
            clr_reg   <= '0;
            pos_reg   <= '0;
            lpos_reg  <= '0;
            sum_reg   <= '0;
            zero_reg  <= 1'b0;
            k_reg     <= '0;
            e_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                F_CLR:  clr_reg <= clr_reg + 1'b1;
                F_IDLE: if (accept) x_reg <= in_sample;
                F_READ:
                begin
                    sq_reg  <= x_sq[rskc_pkg::SQ_W-1:0];
                    old_reg <= sq_rd_reg;
                    d_reg   <= $signed(la_rd_reg);
                    lpos_reg <= (lpos_reg == LA_AW'(LOOKAHEAD - 1)) ? '0 : lpos_reg + 1'b1;
                end
                F_SUM:
                begin
                    sum_reg  <= sum_next;
                    m_reg    <= sum_next;
                    e_reg    <= 6'(SW - 1);
                    zero_reg <= (sum_next == '0);
                    pos_reg  <= (pos_reg == SQ_AW'(RMS_WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                end
                F_NORM:
                begin
                    // byte steps while the top byte is empty, then single bits
                    if (m_reg[SW-1])
                    begin
                        mant_reg <= m_reg[SW-1:SW-31];
                        lg_reg   <= '0;
                        k_reg    <= '0;
                    end
                    else if (m_reg[SW-1:SW-8] == 8'd0)
                    begin
                        m_reg <= m_reg << 8;
                        e_reg <= e_reg - 6'd8;
                    end
                    else
                    begin
                        m_reg <= m_reg << 1;
                        e_reg <= e_reg - 6'd1;
                    end
                end
                F_LOG:
                begin
                    mant_reg <= msq[61] ? msq[61:31] : msq[60:30];
                    lg_reg   <= {lg_reg[14:0], msq[61]};
                    k_reg    <= k_reg + 4'd1;
                end
                F_LVL:  lprod_reg <= 40'({e_reg, lg_reg} * rskc_pkg::LOG_SCALE);
                F_PUSH: ;
                default: ;
            endcase
        end
    end

endmodule

/* design/rskc_back.sv */
// Back end: soft-knee gain computer, exp conversion, envelope and output stage.
// Depends on rskc_pkg for configuration and item types and the exp table.
module rskc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rskc_pkg::rskc_cfg_t  cfg,
    input  logic                 q_empty,
    input  rskc_pkg::rskc_item_t q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [15:0]   out_sample
);

    localparam rskc_pkg::exp_tab_t EXP_C = rskc_pkg::exp_table();
    localparam int EW = rskc_pkg::ENV_W;

    typedef enum logic [10:0] {
        B_IDLE = 11'b000_0000_0001,
        B_GAIN = 11'b000_0000_0010,
        B_DIV  = 11'b000_0000_0100,
        B_RED  = 11'b000_0000_1000,
        B_T    = 11'b000_0001_0000,
        B_EXP  = 11'b000_0010_0000,
        B_DEST = 11'b000_0100_0000,
        B_ELO  = 11'b000_1000_0000,
        B_EHI  = 11'b001_0000_0000,
        B_EUPD = 11'b010_0000_0000,
        B_OUT  = 11'b100_0000_0000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic signed [15:0] lvl_reg, d_reg;
    logic [15:0]        osh_reg;
    logic               use_div_reg;
    logic [29:0]        num_reg;
    logic [12:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic [15:0]        red_reg;
    logic [5:0]         n_reg;
    logic [15:0]        f_reg;
    logic [30:0]        g_reg;
    logic [3:0]         k_reg;
    logic [EW-1:0]      env_reg, diff_reg;
    logic               falls_reg;
    logic [36:0]        lo_reg, hi_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_reg;

    logic signed [17:0] lower, lvl18, over;
    logic               above, in_knee;
    logic [13:0]        rem_sh;
    logic               ge;
    logic [16:0]        rat;
    logic [32:0]        red_prod;
    logic [29:0]        t;
    logic [61:0]        gprod;
    logic [EW-1:0]      dest;
    logic [23:0]        coef;
    logic [48:0]        step;
    logic signed [41:0] p;
    logic signed [17:0] r;
    logic signed [15:0] sat;
    logic               out_load;

    assign lvl18   = 18'(lvl_reg);
    assign lower   = 18'(cfg.threshold_db) - $signed({6'd0, cfg.knee_width_db[12:1]});
    assign over    = lvl18 - lower;
    assign above   = (lvl18 > lower);
    assign in_knee = ({2'b00, over[15:0]} < {5'd0, cfg.knee_width_db});

    assign rem_sh  = {rem_reg, num_reg[29]};
    assign ge      = (rem_sh >= {1'b0, cfg.knee_width_db});

    assign rat      = use_div_reg ? (17'd65536 - quo_reg) : {1'b0, cfg.reduction_fraction};
    assign red_prod = {17'd0, osh_reg} * {16'd0, rat};
    assign t        = 30'({14'd0, red_reg} * {16'd0, rskc_pkg::EXP_SCALE});
    assign gprod    = {31'd0, g_reg} * {31'd0, EXP_C[k_reg]};
    assign dest     = (n_reg >= 6'd31) ? '0 : (g_reg[30:6] >> n_reg);
    assign coef     = falls_reg ? cfg.attack_coef : cfg.release_coef;
    assign step     = {hi_reg, 12'd0} + {12'd0, lo_reg};

    // rounded Q1.15 output, floor((d*g + 2^23) / 2^24), then saturated
    assign p   = $signed(d_reg) * $signed({1'b0, env_reg}) + 42'sd8388608;
    assign r   = p[41:24];
    assign sat = (r > 18'sd32767) ? 16'sd32767 :
                 (r < -18'sd32768) ? -16'sd32768 : r[15:0];

    assign out_load   = (state_reg == B_OUT) && (!out_valid_reg || pop);
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign empty      = !out_valid_reg;
    assign out_sample = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_GAIN;
            B_GAIN:
            begin
                if (!above)       state_next = B_T;
                else if (in_knee) state_next = B_DIV;
                else              state_next = B_RED;
            end
            B_DIV:  if (cnt_reg == 5'd29) state_next = B_RED;
            B_RED:  state_next = B_T;
            B_T:    state_next = B_EXP;
            B_EXP:  if (k_reg == 4'd15) state_next = B_DEST;
            B_DEST: state_next = B_ELO;
            B_ELO:  state_next = B_EHI;
            B_EHI:  state_next = B_EUPD;
            B_EUPD: state_next = B_OUT;
            B_OUT:  if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            env_reg       <= rskc_pkg::UNITY;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= sat;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                if (!q_empty)
                begin
                    lvl_reg <= q_data.level;
                    d_reg   <= q_data.delayed;
                end
                B_GAIN:
                begin
                    osh_reg     <= over[15:0];
                    use_div_reg <= in_knee;
                    red_reg     <= '0;
                    num_reg     <= 30'(over[12:0] * (17'd65536 - {1'b0, cfg.reduction_fraction}));
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    cnt_reg     <= '0;
                end
                B_DIV:
                begin
                    rem_reg <= ge ? 13'(rem_sh - {1'b0, cfg.knee_width_db}) : rem_sh[12:0];
                    quo_reg <= {quo_reg[15:0], ge};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                B_RED:  red_reg <= red_prod[31:16];
                B_T:
                begin
                    n_reg <= t[29:24];
                    f_reg <= t[23:8];
                    g_reg <= 31'h4000_0000;
                    k_reg <= '0;
                end
                B_EXP:
                begin
                    if (f_reg[4'd15 - k_reg]) g_reg <= gprod[60:30];
                    k_reg <= k_reg + 4'd1;
                end
                B_DEST:
                begin
                    falls_reg <= (env_reg > dest);
                    diff_reg  <= (env_reg > dest) ? env_reg - dest : dest - env_reg;
                end
                B_ELO:  lo_reg <= {12'd0, diff_reg} * {25'd0, coef[11:0]};
                B_EHI:  hi_reg <= {12'd0, diff_reg} * {25'd0, coef[23:12]};
                B_EUPD: env_reg <= falls_reg ? env_reg - step[48:24] : env_reg + step[48:24];
                B_OUT:  ;
                default: ;
            endcase
        end
    end

endmodule

/* design/rms_soft_knee_compressor.sv */
// From accept to result: the front runs READ and SUM, then PUSH for a silent window, or
// 1 to 12 normalize steps, 16 log steps and LVL first; the queue then hands it to the back.
// Front and back work on separate items at once; the back is slowest inside the knee (30-step
// divider). Neither takes a new item until its last one is queued or loaded for output.
// Reset: async, active low. Both rings are zeroed by a sweep of max(RMS_WINDOW, LOOKAHEAD)
// words with full held high; config is taken throughout; registers to defaults, envelope unity.
module rms_soft_knee_compressor #(
    parameter int RMS_WINDOW = rskc_pkg::RMS_WINDOW_DEF,
    parameter int LOOKAHEAD  = rskc_pkg::LOOKAHEAD_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [15:0]            in_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [15:0]            out_sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rskc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rskc_pkg::CDAT_W-1:0]   cfg_data
);

    rskc_pkg::rskc_cfg_t      cfg_reg;
    rskc_pkg::rskc_item_t     qw_data, qr_data;
    rskc_pkg::rskc_front_st_t front_st;
    logic                     q_push, q_full, q_pop, q_empty;

    // config port never stalls; an index past the last register is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db       <= rskc_pkg::THRESHOLD_RST;
            cfg_reg.knee_width_db      <= rskc_pkg::KNEE_RST;
            cfg_reg.reduction_fraction <= rskc_pkg::REDUCTION_RST;
            cfg_reg.attack_coef        <= rskc_pkg::ATTACK_RST;
            cfg_reg.release_coef       <= rskc_pkg::RELEASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rskc_pkg::CFG_THRESHOLD: cfg_reg.threshold_db       <= $signed(cfg_data[15:0]);
                rskc_pkg::CFG_KNEE:      cfg_reg.knee_width_db      <= cfg_data[12:0];
                rskc_pkg::CFG_REDUCTION: cfg_reg.reduction_fraction <= cfg_data[15:0];
                rskc_pkg::CFG_ATTACK:    cfg_reg.attack_coef        <= cfg_data;
                rskc_pkg::CFG_RELEASE:   cfg_reg.release_coef       <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: rings, running sum of squares, level in Q8.8 dB
    rskc_front #(
        .RMS_WINDOW (RMS_WINDOW),
        .LOOKAHEAD  (LOOKAHEAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_sample (in_sample),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (qw_data),
        .status    (front_st)
    );

    // decouples level detection from gain/envelope work
    rskc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (qw_data),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (qr_data),
        .empty (q_empty)
    );

    // back: knee, exp, envelope, output register
    rskc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (qr_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_sample (out_sample)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full)) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty)) else $error("queue read while empty");
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        front_st.clearing |-> full) else $error("item taken during ring clear");
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> front_st.busy) else $error("front did not start item");
`endif

endmodule
